### rtl/core/bsa_pkg.sv
// shared constants, codes and helpers of the bitmap slot allocator
`default_nettype none

package bsa_pkg;

    // fixed field widths
    localparam int IDX_W  = 12;
    localparam int CFG_W  = 13;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [CFG_W-1:0] SLOTS_RESET = 13'd4096;

    // request kinds
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEST    = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NONE  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FREE  = 2'd3;

    // position of the lowest set bit, zero when none is set
    function automatic logic [5:0] first_one(input logic [63:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bsa_ram.sv
// generic simple dual-port ram with one write port and a registered read port
`default_nettype none

module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/bitmap_slot_allocator_top.sv
// top level of the bitmap slot allocator: free map, summary map and request sequencer
//
// usage
//   requests arrive on the input channel (i_in_valid / o_in_stall with fields
//   i_mode and i_slot_index); each one yields exactly one result transfer on
//   the output channel (o_out_valid / i_out_stall with o_allocated_index,
//   o_slot_free and o_status). a transfer happens at a clock edge with valid
//   high and stall low.
//   the free map sits in a ram of NWORDS words, one bit per slot; a summary
//   ram keeps one bit per map word that is set while that word has a free bit.
//   states passed, from the input transfer to the result being loaded:
//     out of range or unknown mode : S_IDLE, S_OUT
//     release / test               : S_IDLE, S_DCHK (one map and summary read), S_OUT
//     allocate                     : S_IDLE, S_SCHK scanning summary words in order
//                                    up to a nonzero one, S_DCHK, S_OUT;
//                                    no free slot at all: S_SCHK over all NSUM words, S_OUT
//   one request in flight; the input stalls until its result is in the output
//   register, so the next request can be taken in the cycle after that load
//   after reset a clearing pass writes every map word to all ones, with the
//   input stalled; the slot count register r_slots resets to 4096. an output
//   stall holds the result and freezes the block once the next result is
//   ready; config writes are taken at any time.
`default_nettype none

module bitmap_slot_allocator_top #(
    parameter int MAX_SLOTS  = 4096,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [bsa_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [bsa_pkg::IDX_W-1:0]         i_slot_index,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [bsa_pkg::IDX_W-1:0]         o_allocated_index,
    output logic                                   o_slot_free,
    output logic      [bsa_pkg::STAT_W-1:0]        o_status,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bsa_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [bsa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [bsa_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    // geometry of the map and the summary
    localparam int NWORDS  = (MAX_SLOTS + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam int NSUM    = (NWORDS + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam int BIT_W   = $clog2(WORD_WIDTH);
    localparam int WADDR_W = NWORDS > 1 ? $clog2(NWORDS) : 1;
    localparam int SADDR_W = NSUM > 1 ? $clog2(NSUM) : 1;
    localparam int SW_W    = SADDR_W + BIT_W;
    localparam int FOUND_W = SADDR_W + 2 * BIT_W;
    localparam int FULL_W  = FOUND_W > bsa_pkg::IDX_W ? FOUND_W : bsa_pkg::IDX_W;
    localparam int LIVE_W  = $clog2(MAX_SLOTS + 1);
    localparam int CNT_W   = LIVE_W > bsa_pkg::CFG_W ? LIVE_W : bsa_pkg::CFG_W;
    localparam int CMP_W   = CNT_W > FULL_W ? CNT_W : FULL_W;

    // sequencer states
    localparam logic [2:0] S_INIT = 3'd0;  // clearing pass
    localparam logic [2:0] S_IDLE = 3'd1;  // waiting for a request
    localparam logic [2:0] S_SCHK = 3'd2;  // summary word on the read port
    localparam logic [2:0] S_DCHK = 3'd3;  // map word on the read port
    localparam logic [2:0] S_OUT  = 3'd4;  // write back and load the result

    logic [2:0]                   r_state, n_state;
    logic [WADDR_W-1:0]           r_clr, n_clr;
    logic [SADDR_W-1:0]           r_sidx, n_sidx;
    logic [BIT_W-1:0]             r_sbit, n_sbit;
    logic [WORD_WIDTH-1:0]        r_sword, n_sword;
    logic [bsa_pkg::MODE_W-1:0]   r_mode, n_mode;
    logic [FULL_W-1:0]            r_slot, n_slot;

    // pending result and write back
    logic [bsa_pkg::IDX_W-1:0]    r_res_idx, n_res_idx;
    logic                         r_res_free, n_res_free;
    logic [bsa_pkg::STAT_W-1:0]   r_res_st, n_res_st;
    logic                         r_dwe, n_dwe;
    logic [WADDR_W-1:0]           r_dwaddr, n_dwaddr;
    logic [WORD_WIDTH-1:0]        r_dwdata, n_dwdata;
    logic                         r_swe, n_swe;
    logic [SADDR_W-1:0]           r_swaddr, n_swaddr;
    logic [WORD_WIDTH-1:0]        r_swdata, n_swdata;

    // output register
    logic                         r_out_valid;
    logic [bsa_pkg::IDX_W-1:0]    r_out_idx;
    logic                         r_out_free;
    logic [bsa_pkg::STAT_W-1:0]   r_out_st;

    logic [bsa_pkg::CFG_W-1:0]    r_slots;

    // ram ports
    logic                         map_we, sum_we;
    logic [WADDR_W-1:0]           map_waddr, map_raddr;
    logic [SADDR_W-1:0]           sum_waddr, sum_raddr;
    logic [WORD_WIDTH-1:0]        map_wdata, map_rdata, sum_wdata, sum_rdata;

    logic                         cfg_wr;
    logic                         out_free;
    logic                         in_xfer;
    logic [CMP_W-1:0]             live_cnt;
    logic [FULL_W-1:0]            in_slot;
    logic [WORD_WIDTH-1:0]        init_sum;
    logic [5:0]                   sum_first, map_first;
    logic [SW_W-1:0]              scan_word;
    logic [FULL_W-1:0]            found;
    logic [WORD_WIDTH-1:0]        dbit_mask, sbit_mask, alloc_word;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ?
                    bsa_pkg::APB_DATA_W'(r_slots) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= bsa_pkg::SLOTS_RESET;
        end else if (cfg_wr) begin
            r_slots <= pwdata[bsa_pkg::CFG_W-1:0];
        end
    end

    // effective count saturates at the map size
    assign live_cnt = (CMP_W'(r_slots) > CMP_W'(MAX_SLOTS)) ?
                      CMP_W'(MAX_SLOTS) : CMP_W'(r_slots);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid & ~o_in_stall;
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign in_slot    = FULL_W'(i_slot_index);

    // summary word written by the clearing pass: one bit per existing map word
    always_comb begin
        for (int b = 0; b < WORD_WIDTH; b++) begin
            init_sum[b] = ({r_clr, BIT_W'(b)} < (WADDR_W + BIT_W + 1)'(NWORDS));
        end
    end

    assign sum_first = bsa_pkg::first_one(64'(sum_rdata));
    assign map_first = bsa_pkg::first_one(64'(map_rdata));
    assign scan_word = {r_sidx, sum_first[BIT_W-1:0]};
    assign found     = FULL_W'({r_sidx, r_sbit, map_first[BIT_W-1:0]});

    // masks of the bit under work in the map word and in the summary word
    always_comb begin
        if (r_mode == bsa_pkg::MODE_ALLOC) begin
            dbit_mask = WORD_WIDTH'(1) << map_first[BIT_W-1:0];
            sbit_mask = WORD_WIDTH'(1) << r_sbit;
        end else begin
            dbit_mask = WORD_WIDTH'(1) << r_slot[BIT_W-1:0];
            sbit_mask = WORD_WIDTH'(1) << r_slot[BIT_W +: BIT_W];
        end
    end
    assign alloc_word = map_rdata & ~dbit_mask;

    // read addresses
    always_comb begin
        map_raddr = in_slot[BIT_W +: WADDR_W];
        sum_raddr = '0;
        if (r_state == S_IDLE) begin
            if (i_mode != bsa_pkg::MODE_ALLOC) begin
                sum_raddr = in_slot[2 * BIT_W +: SADDR_W];
            end
        end else if (r_state == S_SCHK) begin
            map_raddr = scan_word[WADDR_W-1:0];
            sum_raddr = r_sidx + SADDR_W'(1);
        end
    end

    // write ports: clearing pass or write back
    always_comb begin
        if (r_state == S_INIT) begin
            map_we    = 1'b1;
            map_waddr = r_clr;
            map_wdata = '1;
            sum_we    = (CMP_W'(r_clr) < CMP_W'(NSUM));
            sum_waddr = r_clr[SADDR_W-1:0];
            sum_wdata = init_sum;
        end else begin
            map_we    = (r_state == S_OUT) & out_free & r_dwe;
            map_waddr = r_dwaddr;
            map_wdata = r_dwdata;
            sum_we    = (r_state == S_OUT) & out_free & r_swe;
            sum_waddr = r_swaddr;
            sum_wdata = r_swdata;
        end
    end

    // map word address of the word found by the summary scan
    function automatic logic [WADDR_W-1:0] scan_word_reg();
        logic [SW_W-1:0] w;
        w = {r_sidx, r_sbit};
        return w[WADDR_W-1:0];
    endfunction

    // request sequencer
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_sidx     = r_sidx;
        n_sbit     = r_sbit;
        n_sword    = r_sword;
        n_mode     = r_mode;
        n_slot     = r_slot;
        n_res_idx  = r_res_idx;
        n_res_free = r_res_free;
        n_res_st   = r_res_st;
        n_dwe      = r_dwe;
        n_dwaddr   = r_dwaddr;
        n_dwdata   = r_dwdata;
        n_swe      = r_swe;
        n_swaddr   = r_swaddr;
        n_swdata   = r_swdata;

        unique case (r_state)
            S_INIT: begin
                n_clr = r_clr + WADDR_W'(1);
                if (CMP_W'(r_clr) == CMP_W'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_mode     = i_mode;
                    n_slot     = in_slot;
                    n_sidx     = '0;
                    n_dwe      = 1'b0;
                    n_swe      = 1'b0;
                    n_res_idx  = '0;
                    n_res_free = 1'b0;
                    n_res_st   = bsa_pkg::STAT_OK;
                    if (i_mode == bsa_pkg::MODE_ALLOC) begin
                        n_state = S_SCHK;
                    end else if (i_mode != bsa_pkg::MODE_RELEASE &&
                                 i_mode != bsa_pkg::MODE_TEST) begin
                        n_res_st = bsa_pkg::STAT_RANGE;
                        n_state  = S_OUT;
                    end else if (CMP_W'(in_slot) >= live_cnt) begin
                        n_res_st = bsa_pkg::STAT_RANGE;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_DCHK;
                    end
                end
            end
            S_SCHK: begin
                if (sum_rdata != '0) begin
                    // map word read issued this cycle
                    n_sword = sum_rdata;
                    n_sbit  = sum_first[BIT_W-1:0];
                    n_state = S_DCHK;
                end else if (CMP_W'(r_sidx) == CMP_W'(NSUM - 1)) begin
                    n_res_st = bsa_pkg::STAT_NONE;
                    n_state  = S_OUT;
                end else begin
                    n_sidx = r_sidx + SADDR_W'(1);
                end
            end
            S_DCHK: begin
                n_state = S_OUT;
                if (r_mode == bsa_pkg::MODE_ALLOC) begin
                    // lowest free slot overall; at or above the count means none left
                    if (map_rdata == '0 || CMP_W'(found) >= live_cnt) begin
                        n_res_st = bsa_pkg::STAT_NONE;
                    end else begin
                        n_res_idx = found[bsa_pkg::IDX_W-1:0];
                        n_dwe     = 1'b1;
                        n_dwaddr  = scan_word_reg();
                        n_dwdata  = alloc_word;
                        if (alloc_word == '0) begin
                            n_swe    = 1'b1;
                            n_swaddr = r_sidx;
                            n_swdata = r_sword & ~sbit_mask;
                        end
                    end
                end else if (r_mode == bsa_pkg::MODE_RELEASE) begin
                    if ((map_rdata & dbit_mask) != '0) begin
                        n_res_st = bsa_pkg::STAT_FREE;
                    end else begin
                        n_dwe    = 1'b1;
                        n_dwaddr = r_slot[BIT_W +: WADDR_W];
                        n_dwdata = map_rdata | dbit_mask;
                        n_swe    = 1'b1;
                        n_swaddr = r_slot[2 * BIT_W +: SADDR_W];
                        n_swdata = sum_rdata | sbit_mask;
                    end
                end else begin
                    n_res_free = ((map_rdata & dbit_mask) != '0);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr       <= '0;
            r_sidx      <= '0;
            r_dwe       <= 1'b0;
            r_swe       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_sidx  <= n_sidx;
            r_dwe   <= n_dwe;
            r_swe   <= n_swe;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sbit     <= n_sbit;
        r_sword    <= n_sword;
        r_mode     <= n_mode;
        r_slot     <= n_slot;
        r_res_idx  <= n_res_idx;
        r_res_free <= n_res_free;
        r_res_st   <= n_res_st;
        r_dwaddr   <= n_dwaddr;
        r_dwdata   <= n_dwdata;
        r_swaddr   <= n_swaddr;
        r_swdata   <= n_swdata;
        if (r_state == S_OUT && out_free) begin
            r_out_idx  <= r_res_idx;
            r_out_free <= r_res_free;
            r_out_st   <= r_res_st;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_allocated_index = r_out_idx;
    assign o_slot_free       = r_out_free;
    assign o_status          = r_out_st;

    // free map, one bit per slot
    bsa_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (NWORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // summary, one bit per map word holding a free slot
    bsa_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (NSUM)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

endmodule

`default_nettype wire
